>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: lbl");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition: lbl");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

>>> sv/gmp_pkg.sv
// ----------------------------------------------------------------------------
// gmp_pkg
// Types and constants of the grid max pool downsampler.
// ----------------------------------------------------------------------------
package gmp_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_MAX_FACTOR = 16;

   localparam int COST_W     = 8;
   localparam int COORD_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int SIZE_W     = 13;
   localparam int FACTOR_W   = 5;
   localparam int FIFO_DEPTH = 4;

   localparam logic [SIZE_W-1:0]   RST_GRID_WIDTH  = 13'd4096;
   localparam logic [SIZE_W-1:0]   RST_GRID_HEIGHT = 13'd4096;
   localparam logic [FACTOR_W-1:0] RST_POOL_FACTOR = 5'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_POOL_FACTOR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic rd_old;
      logic emit;
      logic done;
   } seg_ctrl_type;

endpackage

>>> sv/gmp_if.sv
// ----------------------------------------------------------------------------
// gmp_if
// Valid/ready channels for input cells and pooled results.
// ----------------------------------------------------------------------------
interface gmp_req_if
   import gmp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] cell_cost;

   modport source (output valid, output cell_cost, input ready);
   modport sink (input valid, input cell_cost, output ready);
endinterface

interface gmp_rsp_if
   import gmp_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COST_W-1:0]  pooled_cost;
   logic [COORD_W-1:0] out_col;
   logic [COORD_W-1:0] out_row;
   logic               map_done;

   modport source (output valid, output pooled_cost, output out_col, output out_row,
                   output map_done, input ready);
   modport sink (input valid, input pooled_cost, input out_col, input out_row,
                 input map_done, output ready);
endinterface

>>> sv/gmp_fifo.sv
// ----------------------------------------------------------------------------
// gmp_fifo
// Short segment queue between the classifier and the row store stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmp_fifo
   import gmp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_no_push_full, clock, reset, push && full && !pop)
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && !not_empty)
   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CW'(DEPTH))

endmodule

>>> sv/gmp_front.sv
// ----------------------------------------------------------------------------
// gmp_front
// Tracks the raster position, keeps the segment maximum and queues segments.
// ----------------------------------------------------------------------------
module gmp_front
   import gmp_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_FACTOR = DEF_MAX_FACTOR,
   parameter int XW         = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_data,
   gmp_req_if.sink               req,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [COST_W-1:0]     q_cost,
   output logic [XW-1:0]         q_col,
   output logic [COORD_W-1:0]    q_row,
   output seg_ctrl_type          q_ctrl
);
   localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int BW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
   localparam int WCW = $clog2(MAX_WIDTH + 1);
   localparam int HCW = $clog2(MAX_HEIGHT + 1);
   localparam int FCW = $clog2(MAX_FACTOR + 1);

   logic [SIZE_W-1:0]   width_ff, width_in;
   logic [SIZE_W-1:0]   height_ff, height_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [XW-1:0]       x_ff, x_in;
   logic [YW-1:0]       y_ff, y_in;
   logic [BW-1:0]       bc_ff, bc_in;
   logic [BW-1:0]       br_ff, br_in;
   logic [XW-1:0]       ox_ff, ox_in;
   logic [YW-1:0]       oy_ff, oy_in;
   logic [COST_W-1:0]   run_ff, run_in;

   logic [WCW-1:0]    w_eff;
   logic [HCW-1:0]    h_eff;
   logic [FCW-1:0]    f_eff;
   logic              accept;
   logic              last_col, last_row, bc_last, br_last;
   logic [COST_W-1:0] run;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WCW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = WCW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HCW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HCW'(MAX_HEIGHT);
      end else begin
         h_eff = HCW'(height_ff);
      end
      if (factor_ff == '0) begin
         f_eff = FCW'(1);
      end else if (32'(factor_ff) > MAX_FACTOR) begin
         f_eff = FCW'(MAX_FACTOR);
      end else begin
         f_eff = FCW'(factor_ff);
      end
   end

   assign accept   = req.valid && req.ready;
   assign req.ready = !q_full;

   assign last_col = (WCW'(x_ff) + WCW'(1)) >= w_eff;
   assign last_row = (HCW'(y_ff) + HCW'(1)) >= h_eff;
   assign bc_last  = (FCW'(bc_ff) + FCW'(1)) >= f_eff;
   assign br_last  = (FCW'(br_ff) + FCW'(1)) >= f_eff;
   assign run      = ((bc_ff == '0) || (req.cell_cost > run_ff)) ? req.cell_cost : run_ff;

   assign q_push      = accept && (last_col || bc_last);
   assign q_cost      = run;
   assign q_col       = ox_ff;
   assign q_row       = COORD_W'(oy_ff);
   assign q_ctrl.rd_old = (br_ff != '0);
   assign q_ctrl.emit   = last_row || br_last;
   assign q_ctrl.done   = last_col && last_row;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      factor_in = factor_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      bc_in     = bc_ff;
      br_in     = br_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      run_in    = run_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_GRID_WIDTH: begin
               width_in = csr_data[SIZE_W-1:0];
            end
            CSR_GRID_HEIGHT: begin
               height_in = csr_data[SIZE_W-1:0];
            end
            CSR_POOL_FACTOR: begin
               factor_in = csr_data[FACTOR_W-1:0];
            end
            default: begin
            end
         endcase
         if (csr_idx == CSR_GRID_WIDTH || csr_idx == CSR_GRID_HEIGHT ||
             csr_idx == CSR_POOL_FACTOR) begin
            x_in   = '0;
            y_in   = '0;
            bc_in  = '0;
            br_in  = '0;
            ox_in  = '0;
            oy_in  = '0;
            run_in = '0;
         end
      end else if (accept) begin
         run_in = run;
         if (last_col) begin
            x_in  = '0;
            bc_in = '0;
            ox_in = '0;
            if (last_row) begin
               y_in  = '0;
               br_in = '0;
               oy_in = '0;
            end else begin
               y_in = y_ff + YW'(1);
               if (br_last) begin
                  br_in = '0;
                  oy_in = oy_ff + YW'(1);
               end else begin
                  br_in = br_ff + BW'(1);
               end
            end
         end else begin
            x_in = x_ff + XW'(1);
            if (bc_last) begin
               bc_in = '0;
               ox_in = ox_ff + XW'(1);
            end else begin
               bc_in = bc_ff + BW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_GRID_WIDTH;
         height_ff <= RST_GRID_HEIGHT;
         factor_ff <= RST_POOL_FACTOR;
         x_ff      <= '0;
         y_ff      <= '0;
         bc_ff     <= '0;
         br_ff     <= '0;
         ox_ff     <= '0;
         oy_ff     <= '0;
         run_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         factor_ff <= factor_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         bc_ff     <= bc_in;
         br_ff     <= br_in;
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         run_ff    <= run_in;
      end
   end

endmodule

>>> sv/gmp_back.sv
// ----------------------------------------------------------------------------
// gmp_back
// Merges segments with the row store and drives the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmp_back
   import gmp_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int XW        = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  logic [COST_W-1:0]  q_cost,
   input  logic [XW-1:0]      q_col,
   input  logic [COORD_W-1:0] q_row,
   input  seg_ctrl_type       q_ctrl,
   output logic               q_pop,
   gmp_rsp_if.source          rsp
);
   logic [COST_W-1:0] row_mem [MAX_WIDTH];

   logic               b_vld_ff, b_vld_in;
   logic [COST_W-1:0]  b_cost_ff;
   logic [XW-1:0]      b_ox_ff;
   logic [COORD_W-1:0] b_oy_ff;
   seg_ctrl_type       b_ctrl_ff;
   logic [COST_W-1:0]  rd_data_ff;
   logic               fwd_ff;
   logic [COST_W-1:0]  fwd_data_ff;

   logic               rsp_vld_ff, rsp_vld_in;
   logic [COST_W-1:0]  rsp_cost_ff;
   logic [COORD_W-1:0] rsp_col_ff;
   logic [COORD_W-1:0] rsp_row_ff;
   logic               rsp_done_ff;

   logic              b_fire;
   logic              b_write;
   logic              b_out;
   logic [COST_W-1:0] prev;
   logic [COST_W-1:0] merged;

   assign b_fire  = b_vld_ff && (!b_ctrl_ff.emit || !rsp_vld_ff || rsp.ready);
   assign b_write = b_fire && !b_ctrl_ff.emit;
   assign b_out   = b_fire && b_ctrl_ff.emit;
   assign q_pop   = q_valid && (!b_vld_ff || b_fire);

   assign prev   = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign merged = (b_ctrl_ff.rd_old && (prev > b_cost_ff)) ? prev : b_cost_ff;

   assign b_vld_in   = q_pop || (b_vld_ff && !b_fire);
   assign rsp_vld_in = b_out || (rsp_vld_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_cost_ff   <= q_cost;
         b_ox_ff     <= q_col;
         b_oy_ff     <= q_row;
         b_ctrl_ff   <= q_ctrl;
         rd_data_ff  <= row_mem[q_col];
         fwd_ff      <= b_write && (b_ox_ff == q_col);
         fwd_data_ff <= merged;
      end
      if (b_write) begin
         row_mem[b_ox_ff] <= merged;
      end
      if (b_out) begin
         rsp_cost_ff <= merged;
         rsp_col_ff  <= COORD_W'(b_ox_ff);
         rsp_row_ff  <= b_oy_ff;
         rsp_done_ff <= b_ctrl_ff.done;
      end
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.pooled_cost = rsp_cost_ff;
   assign rsp.out_col     = rsp_col_ff;
   assign rsp.out_row     = rsp_row_ff;
   assign rsp.map_done    = rsp_done_ff;

   `ASSERT_PROP(a_stage_hold, clock, reset, b_vld_ff && !b_fire |=> b_vld_ff && $stable(b_ox_ff))

endmodule

>>> sv/grid_max_pool_downsampler.sv
// ----------------------------------------------------------------------------
// grid_max_pool_downsampler
// Streaming max pooling of a raster cost grid into a coarse grid.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   req_if   in   valid/ready   cell_cost
//   rsp_if   out  valid/ready   pooled_cost, out_col, out_row, map_done
//   csr      in   csr_we        csr_idx, csr_data
//
// One cell per cycle sustained while req_if.ready is high; a result is offered
// once the cell closing its block has passed the segment queue pop, the row
// store merge stage and the result register.
// Synchronous reset; the row store needs no clearing pass.
// A stalled result holds the merge stage once it carries an emitting segment;
// the four-entry segment queue then fills and req_if.ready drops.
// ----------------------------------------------------------------------------
module grid_max_pool_downsampler
   import gmp_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_data,
   gmp_req_if.sink               req_if,
   gmp_rsp_if.source             rsp_if
);
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CTRL_W = $bits(seg_ctrl_type);
   localparam int QW = COST_W + XW + COORD_W + CTRL_W;

   logic               push, full, pop, not_empty;
   logic [COST_W-1:0]  f_cost, h_cost;
   logic [XW-1:0]      f_col, h_col;
   logic [COORD_W-1:0] f_row, h_row;
   seg_ctrl_type       f_ctrl, h_ctrl;
   logic [QW-1:0]      push_word, head_word;

   gmp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_FACTOR (MAX_FACTOR),
      .XW         (XW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_data (csr_data),
      .req      (req_if),
      .q_full   (full),
      .q_push   (push),
      .q_cost   (f_cost),
      .q_col    (f_col),
      .q_row    (f_row),
      .q_ctrl   (f_ctrl)
   );

   assign push_word = {f_cost, f_col, f_row, f_ctrl};
   assign {h_cost, h_col, h_row, h_ctrl} = head_word;

   gmp_fifo #(
      .WIDTH (QW),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_data (head_word)
   );

   gmp_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .XW        (XW)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (not_empty),
      .q_cost  (h_cost),
      .q_col   (h_col),
      .q_row   (h_row),
      .q_ctrl  (h_ctrl),
      .q_pop   (pop),
      .rsp     (rsp_if)
   );

endmodule

>>> tb/tb_grid_max_pool_downsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_max_pool_downsampler
// Streams raster cost grids through the max pool downsampler under several
// grid and factor settings, zero and saturating values among them. A
// scoreboard tracks block maxima per coarse column and checks every pooled
// item in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_grid_max_pool_downsampler;
   import gmp_pkg::*;

   localparam int HALF_PERIOD        = 5;
   localparam int RESET_CYCLES       = 7;
   localparam int SETTLE_CYCLES      = 8;
   localparam int RANDOM_CELLS       = 450;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [COST_W-1:0]  cost;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               done;
   } pooled_type;

   class pool_scoreboard_type;
      int unsigned grid_w;
      int unsigned grid_h;
      int unsigned factor;
      int unsigned col;
      int unsigned row;
      int unsigned blk_col;
      int unsigned blk_row;
      logic [COST_W-1:0] seg_max;
      logic [COST_W-1:0] col_partial [DEF_MAX_WIDTH];
      pooled_type expected_pooled [$];
      int errors;
      int results;

      function new();
         grid_w  = RST_GRID_WIDTH;
         grid_h  = RST_GRID_HEIGHT;
         factor  = RST_POOL_FACTOR;
         errors  = 0;
         results = 0;
         restart();
      endfunction

      function void restart();
         col     = 0;
         row     = 0;
         blk_col = 0;
         blk_row = 0;
         seg_max = '0;
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_GRID_WIDTH:  grid_w = data[SIZE_W-1:0];
            CSR_GRID_HEIGHT: grid_h = data[SIZE_W-1:0];
            CSR_POOL_FACTOR: factor = data[FACTOR_W-1:0];
            default: return;
         endcase
         restart();
      endfunction

      function int pending();
         return expected_pooled.size();
      endfunction

      function void note_cell(logic [COST_W-1:0] c);
         int unsigned w;
         int unsigned h;
         int unsigned f;
         int unsigned ox;
         bit last_col;
         bit last_row;
         bit seg_end;
         bit row_end;
         logic [COST_W-1:0] m;
         pooled_type r;
         w = clamp(grid_w, DEF_MAX_WIDTH);
         h = clamp(grid_h, DEF_MAX_HEIGHT);
         f = clamp(factor, DEF_MAX_FACTOR);
         last_col = (col + 1 >= w);
         last_row = (row + 1 >= h);
         seg_end  = last_col || (blk_col + 1 >= f);
         row_end  = last_row || (blk_row + 1 >= f);
         ox = col / f;
         if (ox >= DEF_MAX_WIDTH) ox = DEF_MAX_WIDTH - 1;
         if (blk_col == 0 || c > seg_max) seg_max = c;
         if (seg_end) begin
            m = seg_max;
            if (blk_row != 0 && col_partial[ox] > m) m = col_partial[ox];
            if (row_end) begin
               r.cost = m;
               r.col  = ox[COORD_W-1:0];
               r.row  = COORD_W'(row / f);
               r.done = last_col && last_row;
               expected_pooled.push_back(r);
            end else begin
               col_partial[ox] = m;
            end
         end
         if (last_col) begin
            col     = 0;
            blk_col = 0;
            if (last_row) begin
               row     = 0;
               blk_row = 0;
            end else begin
               row     = row + 1;
               blk_row = (blk_row + 1 >= f) ? 0 : blk_row + 1;
            end
         end else begin
            col     = col + 1;
            blk_col = (blk_col + 1 >= f) ? 0 : blk_col + 1;
         end
      endfunction

      function void check_pooled(pooled_type got);
         pooled_type want;
         if (expected_pooled.size() == 0) begin
            $error("pooled item with none expected: cost %0d col %0d row %0d done %0d",
                   got.cost, got.col, got.row, got.done);
            errors++;
            return;
         end
         want = expected_pooled.pop_front();
         results++;
         if (got.cost !== want.cost) begin
            $error("pooled_cost: expected %0d, got %0d", want.cost, got.cost);
            errors++;
         end
         if (got.col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, got.col);
            errors++;
         end
         if (got.row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, got.row);
            errors++;
         end
         if (got.done !== want.done) begin
            $error("map_done: expected %0d, got %0d", want.done, got.done);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_data;

   gmp_req_if req_ch ();
   gmp_rsp_if rsp_ch ();

   pool_scoreboard_type sb;
   int req_quiet;
   int rsp_quiet;
   int cells_sent;
   int settings_used;

   grid_max_pool_downsampler i_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_data (csr_data),
      .req_if   (req_ch),
      .rsp_if   (rsp_ch)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int draw_wait(ref int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [COST_W-1:0] draw_cost();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return COST_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we   <= 1'b1;
      csr_idx  <= idx;
      csr_data <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_cell(input logic [COST_W-1:0] c);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cell_cost <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_cell(c);
      cells_sent++;
      @(negedge clock);
   endtask

   // drop valid, drain expected items, then let in-flight cells retire
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [FACTOR_W-1:0] f, input int n_cells,
                            input bit pause_mid);
      write_csr(CSR_GRID_WIDTH, w);
      write_csr(CSR_GRID_HEIGHT, h);
      write_csr(CSR_POOL_FACTOR, CSR_DATA_W'(f));
      settings_used++;
      for (int i = 0; i < n_cells; i++) begin
         if (pause_mid && i == n_cells / 2) begin
            settle();
            write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
         end
         send_cell(draw_cost());
      end
      settle();
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int stall;
         pooled_type got;
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got.cost = rsp_ch.pooled_cost;
         got.col  = rsp_ch.out_col;
         got.row  = rsp_ch.out_row;
         got.done = rsp_ch.map_done;
         sb.check_pooled(got);
         @(negedge clock);
      end
   end

   initial begin
      int base_cells;
      int first_random;
      int unsigned w;
      int unsigned h;
      int unsigned f;
      int unsigned map_cells;
      int n;
      sb = new();
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_idx          = '0;
      csr_data         = '0;
      req_ch.valid     = 1'b0;
      req_ch.cell_cost = '0;
      req_quiet        = 0;
      rsp_quiet        = 0;
      cells_sent       = 0;
      settings_used    = 1;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, a partial map that a config write then restarts
      send_cell('0);
      send_cell('1);
      settle();
      run_phase(13'd3, 13'd3, 5'd2, 13, 1'b0);
      run_phase(13'd0, 13'd0, 5'd0, 2, 1'b0);
      run_phase(13'd8191, 13'd0, 5'd31, 16, 1'b0);
      run_phase(13'd0, 13'd8191, 5'd1, 4, 1'b0);

      base_cells   = cells_sent;
      first_random = 1;
      while (cells_sent - base_cells < RANDOM_CELLS) begin
         w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
         h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
         case ($urandom_range(0, 9))
            0: f = 0;
            1: f = $urandom_range(16, 31);
            2: f = $urandom_range(7, 15);
            default: f = $urandom_range(1, 6);
         endcase
         map_cells = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
         if ($urandom_range(0, 4) == 0 && map_cells > 1)
            n = $urandom_range(1, map_cells - 1);
         else
            n = map_cells * $urandom_range(1, 2);
         if (n > RANDOM_CELLS - (cells_sent - base_cells))
            n = RANDOM_CELLS - (cells_sent - base_cells);
         run_phase(SIZE_W'(w), SIZE_W'(h), FACTOR_W'(f), n,
                   first_random || $urandom_range(0, 7) == 0);
         first_random = 0;
      end

      $display("Streamed %0d cells over %0d grid settings, zero and saturating values included;",
               cells_sent, settings_used);
      $display("checked %0d pooled items, %0d mismatches.", sb.results, sb.errors);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
